>>> rtl/hgd_pkg.sv
// Shared constants, op and command codes, and control structs for the heat grid unit.
// No dependencies; every other file imports this package.
package hgd_pkg;

	localparam int TEMP_COLS_DEF = 120;
	localparam int TEMP_ROWS_DEF = 80;

	localparam int OP_W    = 3;
	localparam int INDEX_W = 14;
	localparam int TEMP_W  = 8;
	localparam int MASK_W  = 64;
	localparam int BOUND_W = 6;

	localparam logic [TEMP_W-1:0] AMBIENT_RESET = 8'd20;
	localparam int TILES_PER_ROW = 6;

	localparam logic [OP_W-1:0] OP_WR_TEMP  = 3'd0;
	localparam logic [OP_W-1:0] OP_RD_TEMP  = 3'd1;
	localparam logic [OP_W-1:0] OP_STEP     = 3'd2;
	localparam logic [OP_W-1:0] OP_CLEAR    = 3'd3;
	localparam logic [OP_W-1:0] OP_RD_CHUNK = 3'd4;

	localparam int CMD_W = 4;
	localparam logic [CMD_W-1:0] CMD_NONE   = 4'd0;
	localparam logic [CMD_W-1:0] CMD_ACCEPT = 4'd1;
	localparam logic [CMD_W-1:0] CMD_INIT   = 4'd2;
	localparam logic [CMD_W-1:0] CMD_DEC_RD = 4'd3;
	localparam logic [CMD_W-1:0] CMD_DEC_WR = 4'd4;
	localparam logic [CMD_W-1:0] CMD_ST0    = 4'd5;
	localparam logic [CMD_W-1:0] CMD_ST1    = 4'd6;
	localparam logic [CMD_W-1:0] CMD_ST2    = 4'd7;
	localparam logic [CMD_W-1:0] CMD_ST3    = 4'd8;
	localparam logic [CMD_W-1:0] CMD_ST4    = 4'd9;
	localparam logic [CMD_W-1:0] CMD_ST5    = 4'd10;
	localparam logic [CMD_W-1:0] CMD_CLR    = 4'd11;
	localparam logic [CMD_W-1:0] CMD_DONE   = 4'd12;

	typedef struct packed {
		logic [CMD_W-1:0] code;
		logic [OP_W-1:0]  op;
	} cmd_t;

	typedef struct packed {
		logic cell_last;
		logic chunk_last;
		logic st_last;
	} sts_t;

	// Tile bit for a chunk: (cy/5)*6 + cx/10, divisions done by reciprocal
	// multiply (exact for chunk coordinates below 64).
	function automatic logic [BOUND_W-1:0] tile_bit(input logic [BOUND_W-1:0] cx,
			input logic [BOUND_W-1:0] cy);
		logic [13:0] pc;
		logic [13:0] pr;
		logic [6:0]  b;
		pc = 14'(cx) * 14'd205;
		pr = 14'(cy) * 14'd205;
		b = 7'(pr[13:10]) * 7'(TILES_PER_ROW) + 7'(pc[13:11]);
		return b[BOUND_W-1:0];
	endfunction

endpackage

>>> rtl/hgd_channels.sv
// Handshake channel interfaces: request, response and ambient configuration.
// Depends on hgd_pkg for field widths.
interface hgd_req_if;
	import hgd_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [OP_W-1:0]      op;
	logic [INDEX_W-1:0]   index;
	logic [TEMP_W-1:0]    value;
	modport source (output valid, op, index, value, input ready);
	modport sink   (input valid, op, index, value, output ready);
endinterface

interface hgd_rsp_if;
	import hgd_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [TEMP_W-1:0]    data;
	logic [MASK_W-1:0]    tile_mask;
	logic                 any_marked;
	logic [BOUND_W-1:0]   min_col;
	logic [BOUND_W-1:0]   max_col;
	logic [BOUND_W-1:0]   min_row;
	logic [BOUND_W-1:0]   max_row;
	modport source (output valid, data, tile_mask, any_marked, min_col, max_col,
		min_row, max_row, input ready);
	modport sink   (input valid, data, tile_mask, any_marked, min_col, max_col,
		min_row, max_row, output ready);
endinterface

interface hgd_cfg_if;
	import hgd_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [TEMP_W-1:0]    data;
	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

>>> rtl/hgd_ctrl.sv
// Sequencer for the heat grid unit: init sweep, ops, decay and stencil sweeps.
// Depends on hgd_pkg; drives hgd_datapath through cmd_t and reads sts_t.
module hgd_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [hgd_pkg::OP_W-1:0]  in_op,
	output logic                      out_valid,
	input  logic                      out_ready,
	output hgd_pkg::cmd_t             cmd,
	input  hgd_pkg::sts_t             sts
);
	import hgd_pkg::*;

	localparam logic [3:0] S_INIT   = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_DEC_RD = 4'd2;
	localparam logic [3:0] S_DEC_WR = 4'd3;
	localparam logic [3:0] S_ST0    = 4'd4;
	localparam logic [3:0] S_ST1    = 4'd5;
	localparam logic [3:0] S_ST2    = 4'd6;
	localparam logic [3:0] S_ST3    = 4'd7;
	localparam logic [3:0] S_ST4    = 4'd8;
	localparam logic [3:0] S_ST5    = 4'd9;
	localparam logic [3:0] S_CLR    = 4'd10;
	localparam logic [3:0] S_DONE   = 4'd11;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       out_valid_q;
	logic       done_fire;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign done_fire = (state_q == S_DONE) && (!out_valid_q || out_ready);

	always_comb begin
		state_d  = state_q;
		cmd.code = CMD_NONE;
		cmd.op   = in_op;
		case (state_q)
			S_INIT: begin
				cmd.code = CMD_INIT;
				if (sts.cell_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.code = CMD_ACCEPT;
					if (in_op == OP_STEP) state_d = S_DEC_RD;
					else if (in_op == OP_CLEAR) state_d = S_CLR;
					else state_d = S_DONE;
				end
			end
			S_DEC_RD: begin
				cmd.code = CMD_DEC_RD;
				state_d  = S_DEC_WR;
			end
			S_DEC_WR: begin
				cmd.code = CMD_DEC_WR;
				state_d  = sts.cell_last ? S_ST0 : S_DEC_RD;
			end
			S_ST0: begin
				cmd.code = CMD_ST0;
				state_d  = S_ST1;
			end
			S_ST1: begin
				cmd.code = CMD_ST1;
				state_d  = S_ST2;
			end
			S_ST2: begin
				cmd.code = CMD_ST2;
				state_d  = S_ST3;
			end
			S_ST3: begin
				cmd.code = CMD_ST3;
				state_d  = S_ST4;
			end
			S_ST4: begin
				cmd.code = CMD_ST4;
				state_d  = S_ST5;
			end
			S_ST5: begin
				cmd.code = CMD_ST5;
				state_d  = sts.st_last ? S_DONE : S_ST0;
			end
			S_CLR: begin
				cmd.code = CMD_CLR;
				if (sts.chunk_last) state_d = S_DONE;
			end
			S_DONE: begin
				if (done_fire) begin
					cmd.code = CMD_DONE;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (done_fire) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	a_busy_no_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !in_ready) else $error("ready while busy");
	a_st_loop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ST5 && !sts.st_last) |=> (state_q == S_ST0))
		else $error("stencil phase order broken");
	a_valid_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result raised outside done");

endmodule

>>> rtl/hgd_datapath.sv
// Grid datapath: temperature and chunk flag memories, sweep counters, stencil
// accumulator, mark registers and result register. Depends on hgd_pkg.
module hgd_datapath #(
	parameter int TEMP_COLS = hgd_pkg::TEMP_COLS_DEF,
	parameter int TEMP_ROWS = hgd_pkg::TEMP_ROWS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  hgd_pkg::cmd_t                cmd,
	output hgd_pkg::sts_t                sts,
	input  logic [hgd_pkg::INDEX_W-1:0]  in_index,
	input  logic [hgd_pkg::TEMP_W-1:0]   in_value,
	input  logic                         cfg_we,
	input  logic [hgd_pkg::TEMP_W-1:0]   cfg_data,
	output logic [hgd_pkg::TEMP_W-1:0]   out_data,
	output logic [hgd_pkg::MASK_W-1:0]   out_tile_mask,
	output logic                         out_any_marked,
	output logic [hgd_pkg::BOUND_W-1:0]  out_min_col,
	output logic [hgd_pkg::BOUND_W-1:0]  out_max_col,
	output logic [hgd_pkg::BOUND_W-1:0]  out_min_row,
	output logic [hgd_pkg::BOUND_W-1:0]  out_max_row
);
	import hgd_pkg::*;

	localparam int CELLS    = TEMP_COLS * TEMP_ROWS;
	localparam int CH_COLS  = TEMP_COLS / 2;
	localparam int CH_ROWS  = TEMP_ROWS / 2;
	localparam int CHUNKS   = CH_COLS * CH_ROWS;
	localparam int AW       = $clog2(CELLS);
	localparam int CW       = $clog2(CHUNKS);
	localparam int XW       = $clog2(TEMP_COLS);
	localparam int YW       = $clog2(TEMP_ROWS);
	localparam int ST_START = (TEMP_ROWS - 2) * TEMP_COLS + 1;

	logic [TEMP_W-1:0] tmem [CELLS];
	logic              cmem [CHUNKS];

	logic [TEMP_W-1:0]  amb_q;
	logic [OP_W-1:0]    op_q;
	logic [INDEX_W-1:0] idx_q;
	logic [AW-1:0]      a_q;
	logic [XW-1:0]      x_q;
	logic [YW-1:0]      y_q;
	logic [11:0]        acc_q;
	logic [TEMP_W-1:0]  rd_q;
	logic               crd_q;
	logic [MASK_W-1:0]  tile_mask_q;
	logic               marked_q;
	logic [BOUND_W-1:0] min_col_q, max_col_q, min_row_q, max_row_q;

	logic               t_we;
	logic               t_re;
	logic [AW-1:0]      t_wa;
	logic [AW-1:0]      t_ra;
	logic [TEMP_W-1:0]  t_wd;
	logic               c_we;
	logic [CW-1:0]      c_wa;
	logic [CW-1:0]      c_ra;
	logic               c_wd;
	logic               mark;
	logic               off_amb;
	logic [BOUND_W-1:0] cx;
	logic [BOUND_W-1:0] cy;
	logic [CW-1:0]      c_mark_a;
	logic [11:0]        st_sum;

	assign cx       = BOUND_W'(x_q >> 1);
	assign cy       = BOUND_W'(y_q >> 1);
	assign c_mark_a = CW'(int'(cy) * CH_COLS + int'(cx));
	assign off_amb  = (rd_q != amb_q);
	assign mark     = (cmd.code == CMD_DEC_WR) && off_amb
		&& (int'(cx) < CH_COLS) && (int'(cy) < CH_ROWS);
	assign st_sum   = acc_q + 12'(rd_q) * 12'd3;

	assign sts.cell_last  = (a_q == AW'(CELLS - 1));
	assign sts.chunk_last = (a_q == AW'(CHUNKS - 1));
	assign sts.st_last    = (y_q == YW'(1)) && (x_q == XW'(TEMP_COLS - 2));

	always_comb begin
		t_we = 1'b0;
		t_re = 1'b0;
		t_wa = a_q;
		t_wd = in_value;
		t_ra = a_q;
		c_we = 1'b0;
		c_wa = a_q[CW-1:0];
		c_wd = 1'b0;
		c_ra = in_index[CW-1:0];
		case (cmd.code)
			CMD_ACCEPT: begin
				t_re = 1'b1;
				t_ra = in_index[AW-1:0];
				if (cmd.op == OP_WR_TEMP && int'(in_index) < CELLS) begin
					t_we = 1'b1;
					t_re = 1'b0;
					t_wa = in_index[AW-1:0];
				end
			end
			CMD_INIT: begin
				t_we = 1'b1;
				t_wd = AMBIENT_RESET;
				c_we = (int'(a_q) < CHUNKS);
			end
			CMD_DEC_RD: t_re = 1'b1;
			CMD_DEC_WR: begin
				t_we = off_amb;
				t_wd = (rd_q > amb_q) ? rd_q - 8'd1 : rd_q + 8'd1;
				c_we = mark;
				c_wa = c_mark_a;
				c_wd = 1'b1;
			end
			CMD_ST0: t_re = 1'b1;
			CMD_ST1: begin
				t_re = 1'b1;
				t_ra = a_q - AW'(1);
			end
			CMD_ST2: begin
				t_re = 1'b1;
				t_ra = a_q + AW'(1);
			end
			CMD_ST3: begin
				t_re = 1'b1;
				t_ra = a_q - AW'(TEMP_COLS);
			end
			CMD_ST4: begin
				t_re = 1'b1;
				t_ra = a_q + AW'(TEMP_COLS);
			end
			CMD_ST5: begin
				t_we = 1'b1;
				t_wd = st_sum[11:4];
			end
			CMD_CLR: c_we = 1'b1;
			default: t_we = 1'b0;
		endcase
	end

	// memory writes and reads; read data is held while a result waits
	always_ff @(posedge clk) begin
		if (t_we) tmem[t_wa] <= t_wd;
		if (t_re) rd_q <= tmem[t_ra];
		if (c_we) cmem[c_wa] <= c_wd;
		if (cmd.code == CMD_ACCEPT) crd_q <= cmem[c_ra];
	end

	// latch the request, run the stencil accumulator and load the result register
	always_ff @(posedge clk) begin
		if (cmd.code == CMD_ACCEPT) begin
			op_q  <= cmd.op;
			idx_q <= in_index;
		end
		case (cmd.code)
			CMD_ST1: acc_q <= 12'(rd_q) * 12'd10;
			CMD_ST2, CMD_ST3, CMD_ST4: acc_q <= acc_q + 12'(rd_q);
			default: acc_q <= acc_q;
		endcase
		if (cmd.code == CMD_DONE) begin
			if (op_q == OP_RD_TEMP && int'(idx_q) < CELLS) out_data <= rd_q;
			else if (op_q == OP_RD_CHUNK && int'(idx_q) < CHUNKS)
				out_data <= {{(TEMP_W-1){1'b0}}, crd_q};
			else out_data <= '0;
			out_tile_mask  <= tile_mask_q;
			out_any_marked <= marked_q;
			out_min_col    <= min_col_q;
			out_max_col    <= max_col_q;
			out_min_row    <= min_row_q;
			out_max_row    <= max_row_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amb_q       <= AMBIENT_RESET;
			a_q         <= '0;
			x_q         <= '0;
			y_q         <= '0;
			tile_mask_q <= '0;
			marked_q    <= 1'b0;
			min_col_q   <= '0;
			max_col_q   <= '0;
			min_row_q   <= '0;
			max_row_q   <= '0;
		end else begin
			if (cfg_we) amb_q <= cfg_data;
			case (cmd.code)
				CMD_ACCEPT: begin
					a_q <= '0;
					x_q <= '0;
					y_q <= '0;
					if (cmd.op == OP_CLEAR) begin
						tile_mask_q <= '0;
						marked_q    <= 1'b0;
						min_col_q   <= '0;
						max_col_q   <= '0;
						min_row_q   <= '0;
						max_row_q   <= '0;
					end
				end
				CMD_INIT, CMD_CLR: a_q <= a_q + AW'(1);
				CMD_DEC_WR: begin
					if (sts.cell_last) begin
						a_q <= AW'(ST_START);
						x_q <= XW'(1);
						y_q <= YW'(TEMP_ROWS - 2);
					end else begin
						a_q <= a_q + AW'(1);
						if (x_q == XW'(TEMP_COLS - 1)) begin
							x_q <= '0;
							y_q <= y_q + YW'(1);
						end else begin
							x_q <= x_q + XW'(1);
						end
					end
				end
				CMD_ST5: begin
					if (x_q == XW'(TEMP_COLS - 2)) begin
						x_q <= XW'(1);
						y_q <= y_q - YW'(1);
						a_q <= a_q - AW'(2 * TEMP_COLS - 3);
					end else begin
						x_q <= x_q + XW'(1);
						a_q <= a_q + AW'(1);
					end
				end
				default: a_q <= a_q;
			endcase
			if (mark) begin
				tile_mask_q <= tile_mask_q | (MASK_W'(1) << tile_bit(cx, cy));
				marked_q    <= 1'b1;
				if (!marked_q) begin
					min_col_q <= cx;
					max_col_q <= cx;
					min_row_q <= cy;
					max_row_q <= cy;
				end else begin
					if (cx < min_col_q) min_col_q <= cx;
					if (cx > max_col_q) max_col_q <= cx;
					if (cy < min_row_q) min_row_q <= cy;
					if (cy > max_row_q) max_row_q <= cy;
				end
			end
		end
	end

	a_unmarked_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!marked_q |-> (tile_mask_q == '0)) else $error("tile bits without marks");
	a_marked_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		marked_q |-> (tile_mask_q != '0)) else $error("marks without tile bits");
	a_bounds_order: assert property (@(posedge clk) disable iff (!arst_n)
		marked_q |-> (min_col_q <= max_col_q && min_row_q <= max_row_q))
		else $error("bounds out of order");

endmodule

>>> rtl/heat_grid_decay_and_diffuse_unit.sv
// Heat grid decay and diffuse unit. One item at a time; a result register lets the
// next item enter while a result waits. Write, read, chunk read and bad op items go
// from accept straight to the done state. Clear marks sweeps the flag memory one entry
// a cycle. Step pass: a decay sweep over all cells, then a stencil sweep over the
// interior cells (single-port temperature memory, one access per cycle). After reset
// a clearing pass fills the grid with 20 before the first item.
module heat_grid_decay_and_diffuse_unit #(
	parameter int TEMP_COLS = hgd_pkg::TEMP_COLS_DEF,
	parameter int TEMP_ROWS = hgd_pkg::TEMP_ROWS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	hgd_req_if.sink    req,
	hgd_rsp_if.source  rsp,
	hgd_cfg_if.sink    cfg
);
	import hgd_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg.ready = 1'b1;

	hgd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.in_op     (req.op),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	hgd_datapath #(
		.TEMP_COLS (TEMP_COLS),
		.TEMP_ROWS (TEMP_ROWS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.in_index       (req.index),
		.in_value       (req.value),
		.cfg_we         (cfg.valid),
		.cfg_data       (cfg.data),
		.out_data       (rsp.data),
		.out_tile_mask  (rsp.tile_mask),
		.out_any_marked (rsp.any_marked),
		.out_min_col    (rsp.min_col),
		.out_max_col    (rsp.max_col),
		.out_min_row    (rsp.min_row),
		.out_max_row    (rsp.max_row)
	);

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for heat_grid_decay_and_diffuse_unit at its default 120x80 grid.
// Depends on hgd_pkg and the channel interfaces in rtl/hgd_channels.sv.
module testbench;
	import hgd_pkg::*;

	localparam int COLS    = TEMP_COLS_DEF;
	localparam int ROWS    = TEMP_ROWS_DEF;
	localparam int CELLS   = COLS * ROWS;
	localparam int CCOLS   = COLS / 2;
	localparam int CROWS   = ROWS / 2;
	localparam int CHUNKS  = CCOLS * CROWS;
	localparam int STALL_LIMIT = 300000;

	typedef struct {
		logic [TEMP_W-1:0]  data;
		logic [MASK_W-1:0]  tile_mask;
		logic               any_marked;
		logic [BOUND_W-1:0] min_col;
		logic [BOUND_W-1:0] max_col;
		logic [BOUND_W-1:0] min_row;
		logic [BOUND_W-1:0] max_row;
	} grid_status_t;

	class heat_scoreboard;
		logic [TEMP_W-1:0]  temps [CELLS];
		bit                 heat_flags [CHUNKS];
		logic [MASK_W-1:0]  tiles;
		bit                 marked;
		logic [BOUND_W-1:0] lo_col, hi_col, lo_row, hi_row;
		logic [TEMP_W-1:0]  ambient;
		grid_status_t       awaited [$];
		int                 errors;

		function void reset_grid();
			foreach (temps[i]) temps[i] = AMBIENT_RESET;
			ambient = AMBIENT_RESET;
			clear_marks();
			errors = 0;
		endfunction

		function void clear_marks();
			foreach (heat_flags[i]) heat_flags[i] = 0;
			tiles = '0;
			marked = 0;
			lo_col = '0;
			hi_col = '0;
			lo_row = '0;
			hi_row = '0;
		endfunction

		function void mark(int cx, int cy);
			int tb;
			heat_flags[cy * CCOLS + cx] = 1;
			tb = (cy / 5) * TILES_PER_ROW + cx / 10;
			tiles[tb] = 1'b1;
			if (!marked) begin
				marked = 1;
				lo_col = BOUND_W'(cx);
				hi_col = BOUND_W'(cx);
				lo_row = BOUND_W'(cy);
				hi_row = BOUND_W'(cy);
			end else begin
				if (cx < lo_col) lo_col = BOUND_W'(cx);
				if (cx > hi_col) hi_col = BOUND_W'(cx);
				if (cy < lo_row) lo_row = BOUND_W'(cy);
				if (cy > hi_row) hi_row = BOUND_W'(cy);
			end
		endfunction

		function void run_pass();
			int cx, cy, acc;
			for (int i = 0; i < CELLS; i++) begin
				if (temps[i] != ambient) begin
					temps[i] = (temps[i] > ambient) ? TEMP_W'(temps[i] - 1)
						: TEMP_W'(temps[i] + 1);
					cx = (i % COLS) / 2;
					cy = (i / COLS) / 2;
					if (cx < CCOLS && cy < CROWS) mark(cx, cy);
				end
			end
			// bottom to top, in place: left and lower neighbors are already new
			for (int y = ROWS - 2; y > 0; y--) begin
				for (int x = 1; x < COLS - 1; x++) begin
					acc = 10 * temps[y*COLS + x] + temps[y*COLS + x - 1]
						+ temps[y*COLS + x + 1] + temps[(y-1)*COLS + x]
						+ 3 * temps[(y+1)*COLS + x];
					temps[y*COLS + x] = TEMP_W'(acc >> 4);
				end
			end
		endfunction

		function void note_input(logic [OP_W-1:0] op, logic [INDEX_W-1:0] idx,
				logic [TEMP_W-1:0] val);
			grid_status_t s;
			s.data = '0;
			case (op)
				OP_WR_TEMP:  if (idx < CELLS) temps[idx] = val;
				OP_RD_TEMP:  if (idx < CELLS) s.data = temps[idx];
				OP_STEP:     run_pass();
				OP_CLEAR:    clear_marks();
				OP_RD_CHUNK: if (idx < CHUNKS) s.data = TEMP_W'(heat_flags[idx]);
				default: ;
			endcase
			s.tile_mask = tiles;
			s.any_marked = marked;
			s.min_col = lo_col;
			s.max_col = hi_col;
			s.min_row = lo_row;
			s.max_row = hi_row;
			awaited.push_back(s);
		endfunction

		task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
			$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
			errors++;
		endtask

		task check_result(grid_status_t got);
			grid_status_t w;
			if (awaited.size() == 0) begin
				report_mismatch("unexpected result beat", 64'(got.data), '0);
			end else begin
				w = awaited.pop_front();
				if (got.data !== w.data) report_mismatch("data", got.data, w.data);
				if (got.tile_mask !== w.tile_mask)
					report_mismatch("tile_mask", got.tile_mask, w.tile_mask);
				if (got.any_marked !== w.any_marked)
					report_mismatch("any_marked", got.any_marked, w.any_marked);
				if (got.min_col !== w.min_col) report_mismatch("min_col", got.min_col, w.min_col);
				if (got.max_col !== w.max_col) report_mismatch("max_col", got.max_col, w.max_col);
				if (got.min_row !== w.min_row) report_mismatch("min_row", got.min_row, w.min_row);
				if (got.max_row !== w.max_row) report_mismatch("max_row", got.max_row, w.max_row);
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	hgd_req_if req_ch ();
	hgd_rsp_if rsp_ch ();
	hgd_cfg_if cfg_ch ();

	heat_scoreboard sb;
	int src_idle_pct;
	int snk_idle_pct;
	int quiet_cycles;

	heat_grid_decay_and_diffuse_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch.sink),
		.rsp    (rsp_ch.source),
		.cfg    (cfg_ch.sink)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// monitor both sides; sampled values are the ones before this edge
	always @(posedge clk) begin
		grid_status_t g;
		if (arst_n && req_ch.valid && req_ch.ready)
			sb.note_input(req_ch.op, req_ch.index, req_ch.value);
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			g.data = rsp_ch.data;
			g.tile_mask = rsp_ch.tile_mask;
			g.any_marked = rsp_ch.any_marked;
			g.min_col = rsp_ch.min_col;
			g.max_col = rsp_ch.max_col;
			g.min_row = rsp_ch.min_row;
			g.max_row = rsp_ch.max_row;
			sb.check_result(g);
		end
	end

	always @(posedge clk) begin
		if (!arst_n)
			rsp_ch.ready <= 1'b0;
		else
			rsp_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task send_item(logic [OP_W-1:0] op, logic [INDEX_W-1:0] idx, logic [TEMP_W-1:0] val);
		req_ch.valid <= 1'b1;
		req_ch.op <= op;
		req_ch.index <= idx;
		req_ch.value <= val;
		do @(posedge clk); while (!req_ch.ready);
		if ($urandom_range(99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(6, 1)) @(posedge clk);
		end
	endtask

	task drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.awaited.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task write_ambient(logic [TEMP_W-1:0] lvl);
		drain();
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= lvl;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		sb.ambient = lvl;
	endtask

	task random_items(int n);
		int pick;
		for (int k = 0; k < n; k++) begin
			pick = $urandom_range(99);
			if (pick < 32)
				send_item(OP_WR_TEMP, ($urandom_range(19) == 0) ? $urandom_range(16383, CELLS)
					: $urandom_range(CELLS - 1), $urandom_range(255));
			else if (pick < 58)
				send_item(OP_RD_TEMP, ($urandom_range(19) == 0) ? $urandom_range(16383, CELLS)
					: $urandom_range(CELLS - 1), $urandom_range(255));
			else if (pick < 84)
				send_item(OP_RD_CHUNK, ($urandom_range(9) == 0) ? $urandom_range(16383, CHUNKS)
					: $urandom_range(CHUNKS - 1), $urandom_range(255));
			else if (pick < 89)
				send_item(OP_STEP, $urandom_range(16383), $urandom_range(255));
			else if (pick < 93)
				send_item(OP_CLEAR, $urandom_range(16383), $urandom_range(255));
			else
				send_item($urandom_range(7, 5), $urandom_range(16383), $urandom_range(255));
		end
	endtask

	initial begin
		sb = new();
		sb.reset_grid();
		src_idle_pct = 20;
		snk_idle_pct = 59;
		quiet_cycles = 0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.op = OP_WR_TEMP;
		req_ch.index = '0;
		req_ch.value = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes of cells, chunks, values and every op code
		send_item(OP_WR_TEMP, 14'd0, 8'd255);
		send_item(OP_WR_TEMP, CELLS - 1, 8'd0);
		send_item(OP_WR_TEMP, COLS + 1, 8'd200);
		send_item(OP_WR_TEMP, CELLS - COLS - 2, 8'd5);
		send_item(OP_WR_TEMP, CELLS, 8'd99);
		send_item(OP_WR_TEMP, 14'h3FFF, 8'hAA);
		send_item(OP_RD_TEMP, 14'd0, 8'd0);
		send_item(OP_RD_TEMP, CELLS - 1, 8'd0);
		send_item(OP_RD_TEMP, 14'h3FFF, 8'd0);
		send_item(OP_RD_CHUNK, 14'd0, 8'd0);
		send_item(OP_STEP, 14'd0, 8'd0);
		send_item(OP_RD_TEMP, COLS + 1, 8'd0);
		send_item(OP_RD_TEMP, CELLS - COLS - 2, 8'd0);
		send_item(OP_RD_CHUNK, 14'd0, 8'd0);
		send_item(OP_RD_CHUNK, CHUNKS - 1, 8'd0);
		send_item(OP_RD_CHUNK, CHUNKS, 8'd0);
		send_item(OP_RD_CHUNK, 14'h3FFF, 8'd0);
		send_item(3'd5, 14'h3FFF, 8'hFF);
		send_item(3'd6, 14'd0, 8'd0);
		send_item(3'd7, 14'h1555, 8'h55);
		send_item(OP_CLEAR, 14'd0, 8'd0);
		send_item(OP_RD_CHUNK, 14'd0, 8'd0);
		send_item(OP_RD_TEMP, 14'd0, 8'd0);

		write_ambient(8'd0);
		random_items(25);
		write_ambient(8'd255);
		src_idle_pct = 59;
		snk_idle_pct = 20;
		random_items(26);
		write_ambient($urandom_range(255));
		src_idle_pct = 0;
		snk_idle_pct = 0;
		random_items(26);
		drain();

		if (sb.errors == 0 && sb.awaited.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule

>>> filelist.f
rtl/hgd_pkg.sv
rtl/hgd_channels.sv
rtl/hgd_ctrl.sv
rtl/hgd_datapath.sv
rtl/heat_grid_decay_and_diffuse_unit.sv
tb/testbench.sv
